[sv/voltage_reference_mux_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the voltage reference mux
// Concurrent assertion wrappers that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef VOLTAGE_REFERENCE_MUX_MACROS_SVH
`define VOLTAGE_REFERENCE_MUX_MACROS_SVH

`ifndef ASSERT_OFF
`define VRM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VRM_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define VRM_ASSERT(label, clk, rst_n, prop, msg)
`define VRM_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

[sv/vrm_pkg.sv]
// ----------------------------------------------------------------------------
// Voltage reference mux package
// Shared constants, codes and types of the voltage reference mux.
// ----------------------------------------------------------------------------
package vrm_pkg;

    // Number of reference channels, 1 to 16.
    localparam int CHANNELS = 8;
    localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // A ratio of 1.0 in Q1.12.
    localparam logic [12:0] ONE_Q = 13'd4096;

    // Source codes.
    localparam logic [2:0] SRC_VCC     = 3'd0;
    localparam logic [2:0] SRC_AVCC    = 3'd1;
    localparam logic [2:0] SRC_AREF    = 3'd2;
    localparam logic [2:0] SRC_BANDGAP = 3'd3;
    localparam logic [2:0] SRC_MUX     = 3'd4;

    typedef enum logic [1:0] {
        CMD_GET  = 2'd0,
        CMD_SET  = 2'd1,
        CMD_MUX  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_VCC    = 2'd1,
        KIND_AREF   = 2'd2,
        KIND_CHAN   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_VCC_UNSET = 2'd1,
        STAT_BAD_SRC   = 2'd2,
        STAT_BAD_CHAN  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_NOTE_VCC,
        ST_NOTE_AREF,
        ST_READ,
        ST_MODIFY,
        ST_DIV,
        ST_RESULT,
        ST_FINAL
    } state_t;

    // One channel table entry.
    typedef struct packed {
        logic [2:0]  ref_src;
        logic [16:0] bandgap_volts;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{ref_src: SRC_BANDGAP, bandgap_volts: 17'd0};

    // Access request to the channel table.
    typedef struct packed {
        logic             rd_en;
        logic [CH_AW-1:0] rd_addr;
        logic             wr_en;
        logic [CH_AW-1:0] wr_addr;
        entry_t           wr_data;
    } tbl_req_t;

endpackage

[sv/vrm_table.sv]
// ----------------------------------------------------------------------------
// Channel table
// Synchronous memory of channel entries with a registered read and a
// valid bit per entry so that unwritten entries read as the reset entry.
// ----------------------------------------------------------------------------
module vrm_table
(
    input  logic              clk,
    input  logic              rst_n,
    input  vrm_pkg::tbl_req_t req,
    output vrm_pkg::entry_t   rd_data
);

    vrm_pkg::entry_t             entry_mem [vrm_pkg::CHANNELS];
    logic [vrm_pkg::CHANNELS-1:0] valid_reg;
    vrm_pkg::entry_t             rd_data_reg;
    logic                        rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            entry_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= entry_mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : vrm_pkg::ENTRY_RESET;

endmodule

[sv/vrm_div.sv]
// ----------------------------------------------------------------------------
// Bandgap ratio divider
// Restoring divider that computes floor(bandgap * 4096 / vcc), saturated
// at 4096, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vrm_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [16:0] bg,
    input  logic [15:0] vcc,
    output logic        done,
    output logic [12:0] ratio
);

    logic        busy_reg;
    logic [3:0]  cnt_reg;
    logic [15:0] rem_reg;
    logic [12:0] quot_reg;
    logic [15:0] vcc_reg;
    logic        done_reg;
    logic [12:0] ratio_reg;

    logic        bg_pos;
    logic        bg_sat;
    logic        first_bit;
    logic [16:0] shifted;
    logic        step_bit;
    logic [12:0] quot_step;

    assign bg_pos    = !bg[16] && (bg[15:0] != 16'd0);
    // With bandgap at or above twice vcc the quotient is at least 8192.
    assign bg_sat    = {1'b0, bg[15:0]} >= {vcc, 1'b0};
    assign first_bit = bg[15:0] >= vcc;

    assign shifted   = {rem_reg, 1'b0};
    assign step_bit  = shifted >= {1'b0, vcc_reg};
    assign quot_step = {quot_reg[11:0], step_bit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            cnt_reg   <= 4'd0;
            rem_reg   <= 16'd0;
            quot_reg  <= 13'd0;
            vcc_reg   <= 16'd0;
            done_reg  <= 1'b0;
            ratio_reg <= 13'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                vcc_reg <= vcc;
                if ((vcc == 16'd0) || !bg_pos)
                begin
                    ratio_reg <= 13'd0;
                    done_reg  <= 1'b1;
                end
                else if (bg_sat)
                begin
                    ratio_reg <= vrm_pkg::ONE_Q;
                    done_reg  <= 1'b1;
                end
                else
                begin
                    // The remainder stays below vcc from here on.
                    rem_reg  <= first_bit ? (bg[15:0] - vcc) : bg[15:0];
                    quot_reg <= {12'd0, first_bit};
                    cnt_reg  <= 4'd12;
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                rem_reg  <= step_bit ? 16'(shifted - {1'b0, vcc_reg}) : shifted[15:0];
                quot_reg <= quot_step;
                cnt_reg  <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd1)
                begin
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                    ratio_reg <= (quot_step > vrm_pkg::ONE_Q) ? vrm_pkg::ONE_Q : quot_step;
                end
            end
        end
    end

    assign done  = done_reg;
    assign ratio = ratio_reg;

endmodule

[sv/voltage_reference_mux.sv]
// ----------------------------------------------------------------------------
// Voltage reference mux
// Keeps the supply voltage, the AREF ratio and a table of per-channel mux
// sources and bandgap voltages, and answers get, set and mux commands with
// change notifications followed by one status item that carries tlast. The
// block takes one command at a time. A command that reads a channel entry
// goes through a table read and, for a set or mux, a write-back, plus the
// bit-serial divider when the channel reference comes from its bandgap. A
// VCC write walks all CHANNELS table entries in turn. The table needs no
// clearing pass after reset. Stalls on the result side only hold the
// sequencer.
// ----------------------------------------------------------------------------
`include "voltage_reference_mux_macros.svh"

module voltage_reference_mux
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [2:0] source, [6:3] channel, [23:7] voltage
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [3:0] out_channel, [19:4] value, [21:20] status
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast
);

    localparam int AW = vrm_pkg::CH_AW;

    vrm_pkg::state_t state_reg, state_next;
    logic [1:0]      cmd_reg, cmd_next;
    logic [2:0]      src_reg, src_next;
    logic [3:0]      ch_reg, ch_next;
    logic [16:0]     volt_reg, volt_next;
    logic [15:0]     supply_reg, supply_next;
    logic [12:0]     aref_reg, aref_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [15:0]     value_reg, value_next;
    logic [1:0]      status_reg, status_next;
    logic [12:0]     ref_reg, ref_next;
    logic            emit_reg, emit_next;

    logic            out_valid_reg;
    logic [1:0]      out_kind_reg, out_kind_next;
    logic [3:0]      out_ch_reg, out_ch_next;
    logic [15:0]     out_value_reg, out_value_next;
    logic [1:0]      out_status_reg, out_status_next;
    logic            out_last_reg, out_last_next;
    logic            out_load;
    logic            out_free;

    vrm_pkg::tbl_req_t tbl_req;
    vrm_pkg::entry_t   tbl_rd;
    vrm_pkg::entry_t   new_entry;

    logic        div_start;
    logic        div_done;
    logic [12:0] div_ratio;

    logic        bad_ch;
    logic        vcc_unset;
    logic        sweep;
    logic        use_bg;

    vrm_table u_table
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (tbl_req),
        .rd_data (tbl_rd)
    );

    vrm_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .bg    (new_entry.bandgap_volts),
        .vcc   (supply_reg),
        .done  (div_done),
        .ratio (div_ratio)
    );

    assign bad_ch    = {1'b0, ch_reg} >= 5'(vrm_pkg::CHANNELS);
    assign vcc_unset = supply_reg == 16'd0;
    assign sweep     = (cmd_reg == vrm_pkg::CMD_SET) && (src_reg == vrm_pkg::SRC_VCC);
    assign out_free  = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= vrm_pkg::ST_IDLE;
            cmd_reg        <= 2'd0;
            src_reg        <= 3'd0;
            ch_reg         <= 4'd0;
            volt_reg       <= 17'd0;
            supply_reg     <= 16'd0;
            aref_reg       <= 13'd0;
            idx_reg        <= '0;
            value_reg      <= 16'd0;
            status_reg     <= 2'd0;
            ref_reg        <= 13'd0;
            emit_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= 2'd0;
            out_ch_reg     <= 4'd0;
            out_value_reg  <= 16'd0;
            out_status_reg <= 2'd0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            src_reg    <= src_next;
            ch_reg     <= ch_next;
            volt_reg   <= volt_next;
            supply_reg <= supply_next;
            aref_reg   <= aref_next;
            idx_reg    <= idx_next;
            value_reg  <= value_next;
            status_reg <= status_next;
            ref_reg    <= ref_next;
            emit_reg   <= emit_next;
            if (out_load)
            begin
                out_valid_reg  <= 1'b1;
                out_kind_reg   <= out_kind_next;
                out_ch_reg     <= out_ch_next;
                out_value_reg  <= out_value_next;
                out_status_reg <= out_status_next;
                out_last_reg   <= out_last_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        src_next        = src_reg;
        ch_next         = ch_reg;
        volt_next       = volt_reg;
        supply_next     = supply_reg;
        aref_next       = aref_reg;
        idx_next        = idx_reg;
        value_next      = value_reg;
        status_next     = status_reg;
        ref_next        = ref_reg;
        emit_next       = emit_reg;
        out_load        = 1'b0;
        out_kind_next   = vrm_pkg::KIND_STATUS;
        out_ch_next     = 4'd0;
        out_value_next  = 16'd0;
        out_status_next = vrm_pkg::STAT_OK;
        out_last_next   = 1'b0;
        tbl_req         = '0;
        tbl_req.rd_addr = idx_reg;
        tbl_req.wr_addr = idx_reg;
        new_entry       = tbl_rd;
        tbl_req.wr_data = new_entry;
        div_start       = 1'b0;
        use_bg          = 1'b0;
        s_axis_tready   = 1'b0;

        case (state_reg)
            vrm_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd_next   = s_axis_tuser;
                    src_next   = s_axis_tdata[2:0];
                    ch_next    = s_axis_tdata[6:3];
                    volt_next  = s_axis_tdata[23:7];
                    state_next = vrm_pkg::ST_DECIDE;
                end
            end

            vrm_pkg::ST_DECIDE:
            begin
                value_next  = 16'd0;
                status_next = vrm_pkg::STAT_OK;
                idx_next    = ch_reg[AW-1:0];
                state_next  = vrm_pkg::ST_FINAL;
                case (cmd_reg)
                    vrm_pkg::CMD_GET:
                    begin
                        if (vcc_unset)
                        begin
                            status_next = vrm_pkg::STAT_VCC_UNSET;
                        end
                        else if (src_reg == vrm_pkg::SRC_VCC)
                        begin
                            value_next = supply_reg;
                        end
                        else if (src_reg == vrm_pkg::SRC_AVCC)
                        begin
                            value_next = 16'(vrm_pkg::ONE_Q);
                        end
                        else if (src_reg == vrm_pkg::SRC_AREF)
                        begin
                            value_next = 16'(aref_reg);
                        end
                        else if ((src_reg == vrm_pkg::SRC_BANDGAP) ||
                                 (src_reg == vrm_pkg::SRC_MUX))
                        begin
                            if (bad_ch)
                            begin
                                status_next = vrm_pkg::STAT_BAD_CHAN;
                            end
                            else
                            begin
                                state_next = vrm_pkg::ST_READ;
                            end
                        end
                        else
                        begin
                            status_next = vrm_pkg::STAT_BAD_SRC;
                        end
                    end
                    vrm_pkg::CMD_SET:
                    begin
                        if (vcc_unset && (src_reg != vrm_pkg::SRC_VCC))
                        begin
                            status_next = vrm_pkg::STAT_VCC_UNSET;
                        end
                        else if (src_reg == vrm_pkg::SRC_VCC)
                        begin
                            supply_next = volt_reg[16] ? 16'd0 : volt_reg[15:0];
                            state_next  = vrm_pkg::ST_NOTE_VCC;
                        end
                        else if (src_reg == vrm_pkg::SRC_AREF)
                        begin
                            if (volt_reg[16])
                            begin
                                aref_next = 13'd0;
                            end
                            else if (volt_reg[15:0] > 16'(vrm_pkg::ONE_Q))
                            begin
                                aref_next = vrm_pkg::ONE_Q;
                            end
                            else
                            begin
                                aref_next = volt_reg[12:0];
                            end
                            state_next = vrm_pkg::ST_NOTE_AREF;
                        end
                        else if (src_reg == vrm_pkg::SRC_BANDGAP)
                        begin
                            if (bad_ch)
                            begin
                                status_next = vrm_pkg::STAT_BAD_CHAN;
                            end
                            else
                            begin
                                state_next = vrm_pkg::ST_READ;
                            end
                        end
                        else
                        begin
                            status_next = vrm_pkg::STAT_BAD_SRC;
                        end
                    end
                    vrm_pkg::CMD_MUX:
                    begin
                        if (vcc_unset)
                        begin
                            status_next = vrm_pkg::STAT_VCC_UNSET;
                        end
                        else if (bad_ch)
                        begin
                            status_next = vrm_pkg::STAT_BAD_CHAN;
                        end
                        else if (src_reg > vrm_pkg::SRC_MUX)
                        begin
                            status_next = vrm_pkg::STAT_BAD_SRC;
                        end
                        else
                        begin
                            state_next = vrm_pkg::ST_READ;
                        end
                    end
                    default:
                    begin
                        status_next = vrm_pkg::STAT_OK;
                    end
                endcase
            end

            vrm_pkg::ST_NOTE_VCC:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_kind_next  = vrm_pkg::KIND_VCC;
                    out_value_next = supply_reg;
                    idx_next       = '0;
                    state_next     = vrm_pkg::ST_READ;
                end
            end

            vrm_pkg::ST_NOTE_AREF:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_kind_next  = vrm_pkg::KIND_AREF;
                    out_value_next = 16'(aref_reg);
                    state_next     = vrm_pkg::ST_FINAL;
                end
            end

            vrm_pkg::ST_READ:
            begin
                tbl_req.rd_en = 1'b1;
                state_next    = vrm_pkg::ST_MODIFY;
            end

            vrm_pkg::ST_MODIFY:
            begin
                // The entry is written back here; the next read of the table comes
                // only after ST_RESULT or ST_FINAL, so no forwarding is needed.
                emit_next = 1'b0;
                if ((cmd_reg == vrm_pkg::CMD_SET) && (src_reg == vrm_pkg::SRC_BANDGAP))
                begin
                    new_entry.bandgap_volts = volt_reg;
                    tbl_req.wr_en           = 1'b1;
                    emit_next = tbl_rd.ref_src == vrm_pkg::SRC_BANDGAP;
                end
                else if (cmd_reg == vrm_pkg::CMD_MUX)
                begin
                    new_entry.ref_src = src_reg;
                    if ((src_reg == vrm_pkg::SRC_BANDGAP) && !volt_reg[16])
                    begin
                        new_entry.bandgap_volts = volt_reg;
                    end
                    tbl_req.wr_en = 1'b1;
                    emit_next     = 1'b1;
                end
                else if (sweep)
                begin
                    emit_next = 1'b1;
                end
                tbl_req.wr_data = new_entry;

                // A get of the bandgap source always wants the bandgap ratio.
                use_bg = ((cmd_reg == vrm_pkg::CMD_GET) &&
                          (src_reg == vrm_pkg::SRC_BANDGAP)) ||
                         (new_entry.ref_src == vrm_pkg::SRC_BANDGAP);
                if (use_bg)
                begin
                    div_start  = 1'b1;
                    state_next = vrm_pkg::ST_DIV;
                end
                else
                begin
                    if (vcc_unset)
                    begin
                        ref_next = 13'd0;
                    end
                    else if ((new_entry.ref_src == vrm_pkg::SRC_VCC) ||
                             (new_entry.ref_src == vrm_pkg::SRC_AVCC))
                    begin
                        ref_next = vrm_pkg::ONE_Q;
                    end
                    else if (new_entry.ref_src == vrm_pkg::SRC_AREF)
                    begin
                        ref_next = aref_reg;
                    end
                    else
                    begin
                        ref_next = 13'd0;
                    end
                    state_next = vrm_pkg::ST_RESULT;
                end
            end

            vrm_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    ref_next   = div_ratio;
                    state_next = vrm_pkg::ST_RESULT;
                end
            end

            vrm_pkg::ST_RESULT:
            begin
                if (cmd_reg == vrm_pkg::CMD_GET)
                begin
                    value_next = 16'(ref_reg);
                    state_next = vrm_pkg::ST_FINAL;
                end
                else if (!emit_reg)
                begin
                    state_next = vrm_pkg::ST_FINAL;
                end
                else if (out_free)
                begin
                    out_load       = 1'b1;
                    out_kind_next  = vrm_pkg::KIND_CHAN;
                    out_ch_next    = 4'(idx_reg);
                    out_value_next = 16'(ref_reg);
                    if (sweep && (idx_reg != AW'(vrm_pkg::CHANNELS - 1)))
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = vrm_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = vrm_pkg::ST_FINAL;
                    end
                end
            end

            vrm_pkg::ST_FINAL:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_kind_next   = vrm_pkg::KIND_STATUS;
                    out_value_next  = value_reg;
                    out_status_next = status_reg;
                    out_last_next   = 1'b1;
                    state_next      = vrm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = vrm_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_status_reg, out_value_reg, out_ch_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    // The final status item is the only one that closes a command.
    `VRM_ASSERT(a_last_only_on_status, clk, rst_n,
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == vrm_pkg::KIND_STATUS)),
        "tlast does not match a status item")
    // Notifications never carry an error code.
    `VRM_ASSERT(a_note_status_ok, clk, rst_n,
        (m_axis_tvalid && (m_axis_tuser != vrm_pkg::KIND_STATUS)) |->
            (m_axis_tdata[21:20] == vrm_pkg::STAT_OK),
        "notification with error status")
    // A divider result arrives only while the sequencer waits for it.
    `VRM_ASSERT(a_div_done_waited, clk, rst_n,
        div_done |-> (state_reg == vrm_pkg::ST_DIV),
        "divider result arrived outside the wait state")
    // A ratio never exceeds 1.0.
    `VRM_ASSERT_NEVER(a_div_ratio_range, clk, rst_n,
        div_done && (div_ratio > vrm_pkg::ONE_Q),
        "divider ratio above 1.0")

endmodule

[sim/vrm_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Voltage reference mux result checker
// Watches both stream channels of the voltage reference mux. Every command
// accepted on the input side is run through a local copy of the supply,
// AREF and channel table state, and the change notifications and final
// status item it must produce are queued. Every item taken on the output side
// is compared field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module vrm_result_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          results_due
);

    typedef struct packed {
        vrm_pkg::kind_t   kind;
        logic [3:0]       chan;
        logic [15:0]      value;
        vrm_pkg::status_t status;
        logic             last;
    } reply_t;

    reply_t             reply_q[$];
    reply_t             head;
    logic [15:0]        supply_volts;
    logic [12:0]        aref_ratio;
    logic [2:0]         mux_src [vrm_pkg::CHANNELS];
    logic signed [16:0] bandgap_tbl [vrm_pkg::CHANNELS];
    int                 errors = 0;

    // Bandgap over supply, floored and saturated at 1.0.
    function automatic logic [12:0] bandgap_share(input logic signed [16:0] bg);
        logic [31:0] q;
        if (supply_volts == 16'd0 || bg <= 0)
            return '0;
        q = ({16'd0, bg[15:0]} * 32'(vrm_pkg::ONE_Q)) / {16'd0, supply_volts};
        return (q > 32'(vrm_pkg::ONE_Q)) ? vrm_pkg::ONE_Q : q[12:0];
    endfunction

    function automatic logic [12:0] channel_ref(input int ch);
        if (supply_volts == 16'd0)
            return '0;
        case (mux_src[ch])
            vrm_pkg::SRC_VCC, vrm_pkg::SRC_AVCC: return vrm_pkg::ONE_Q;
            vrm_pkg::SRC_AREF:                   return aref_ratio;
            vrm_pkg::SRC_BANDGAP:                return bandgap_share(bandgap_tbl[ch]);
            default:                             return '0;
        endcase
    endfunction

    task automatic queue_reply(input vrm_pkg::kind_t kind, input logic [3:0] chan,
                               input logic [15:0] value, input vrm_pkg::status_t status,
                               input logic last);
        reply_t r;
        r = '{kind, chan, value, status, last};
        reply_q.push_back(r);
    endtask

    task automatic apply_command(input vrm_pkg::cmd_t cmd, input logic [2:0] src,
                                 input logic [3:0] ch, input logic signed [16:0] v);
        logic [15:0]      value;
        vrm_pkg::status_t status;
        value  = '0;
        status = vrm_pkg::STAT_OK;
        case (cmd)
            vrm_pkg::CMD_GET:
                if (supply_volts == 16'd0)
                    status = vrm_pkg::STAT_VCC_UNSET;
                else if (src == vrm_pkg::SRC_VCC)
                    value = supply_volts;
                else if (src == vrm_pkg::SRC_AVCC)
                    value = 16'(vrm_pkg::ONE_Q);
                else if (src == vrm_pkg::SRC_AREF)
                    value = 16'(aref_ratio);
                else if (src == vrm_pkg::SRC_BANDGAP || src == vrm_pkg::SRC_MUX)
                begin
                    if (ch >= vrm_pkg::CHANNELS)
                        status = vrm_pkg::STAT_BAD_CHAN;
                    else if (src == vrm_pkg::SRC_BANDGAP)
                        value = 16'(bandgap_share(bandgap_tbl[ch]));
                    else
                        value = 16'(channel_ref(ch));
                end
                else
                    status = vrm_pkg::STAT_BAD_SRC;
            vrm_pkg::CMD_SET:
                if (supply_volts == 16'd0 && src != vrm_pkg::SRC_VCC)
                    status = vrm_pkg::STAT_VCC_UNSET;
                else if (src == vrm_pkg::SRC_VCC)
                begin
                    // A supply change re-announces every channel reference.
                    supply_volts = (v < 0) ? 16'd0 : v[15:0];
                    queue_reply(vrm_pkg::KIND_VCC, 4'd0, supply_volts,
                                vrm_pkg::STAT_OK, 1'b0);
                    for (int i = 0; i < vrm_pkg::CHANNELS; i++)
                        queue_reply(vrm_pkg::KIND_CHAN, 4'(i), 16'(channel_ref(i)),
                                    vrm_pkg::STAT_OK, 1'b0);
                end
                else if (src == vrm_pkg::SRC_AREF)
                begin
                    if (v < 0)
                        aref_ratio = '0;
                    else if (v > int'(vrm_pkg::ONE_Q))
                        aref_ratio = vrm_pkg::ONE_Q;
                    else
                        aref_ratio = v[12:0];
                    queue_reply(vrm_pkg::KIND_AREF, 4'd0, 16'(aref_ratio),
                                vrm_pkg::STAT_OK, 1'b0);
                end
                else if (src == vrm_pkg::SRC_BANDGAP)
                begin
                    if (ch >= vrm_pkg::CHANNELS)
                        status = vrm_pkg::STAT_BAD_CHAN;
                    else
                    begin
                        bandgap_tbl[ch] = v;
                        if (mux_src[ch] == vrm_pkg::SRC_BANDGAP)
                            queue_reply(vrm_pkg::KIND_CHAN, ch, 16'(channel_ref(ch)),
                                        vrm_pkg::STAT_OK, 1'b0);
                    end
                end
                else
                    status = vrm_pkg::STAT_BAD_SRC;
            vrm_pkg::CMD_MUX:
                if (supply_volts == 16'd0)
                    status = vrm_pkg::STAT_VCC_UNSET;
                else if (ch >= vrm_pkg::CHANNELS)
                    status = vrm_pkg::STAT_BAD_CHAN;
                else if (src > vrm_pkg::SRC_MUX)
                    status = vrm_pkg::STAT_BAD_SRC;
                else
                begin
                    mux_src[ch] = src;
                    // A negative voltage leaves the stored bandgap alone.
                    if (src == vrm_pkg::SRC_BANDGAP && v >= 0)
                        bandgap_tbl[ch] = v;
                    queue_reply(vrm_pkg::KIND_CHAN, ch, 16'(channel_ref(ch)),
                                vrm_pkg::STAT_OK, 1'b0);
                end
            default:
                ;
        endcase
        queue_reply(vrm_pkg::KIND_STATUS, 4'd0, value, status, 1'b1);
    endtask

    task automatic check_field(input string name, input logic [31:0] wanted,
                               input logic [31:0] seen);
        if (seen !== wanted)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, wanted, seen);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reply_q.delete();
            supply_volts = '0;
            aref_ratio   = '0;
            for (int i = 0; i < vrm_pkg::CHANNELS; i++)
            begin
                mux_src[i]     = vrm_pkg::SRC_BANDGAP;
                bandgap_tbl[i] = '0;
            end
            fail_count  <= 0;
            results_due <= 0;
        end
        else
        begin
            // Outputs first, so an item accepted at the same edge queues behind.
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (reply_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected item, expected none, actual kind %0d value %0d",
                             $time, m_axis_tuser, m_axis_tdata[19:4]);
                end
                else
                begin
                    head = reply_q.pop_front();
                    check_field("kind", 32'(head.kind), 32'(m_axis_tuser));
                    check_field("out_channel", 32'(head.chan), 32'(m_axis_tdata[3:0]));
                    check_field("value", 32'(head.value), 32'(m_axis_tdata[19:4]));
                    check_field("status", 32'(head.status), 32'(m_axis_tdata[21:20]));
                    check_field("last", 32'(head.last), 32'(m_axis_tlast));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                apply_command(vrm_pkg::cmd_t'(s_axis_tuser), s_axis_tdata[2:0],
                              s_axis_tdata[6:3], s_axis_tdata[23:7]);
            fail_count  <= errors;
            results_due <= reply_q.size();
        end
    end

endmodule

[sim/tb_voltage_reference_mux.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Voltage reference mux testbench
// Drives commands into the voltage reference mux: a directed opening over the
// unset supply, clamping, saturation, bad sources and bad channels, then
// random commands in phases with and without idling on either side, and one
// long output stall that backs the block up. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_voltage_reference_mux;

    localparam int ITEMS       = 420;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 200;
    localparam int HOLD_CYCLES = 400;

    // Source codes that the block does not know.
    localparam logic [2:0] SRC_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] SRC_UNUSED_LAST  = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int fail_count;
    int results_due;
    int idle_pct = 0;
    int stall_pct = 0;
    int cycles = 0;
    int hold_left = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    voltage_reference_mux dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    vrm_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .results_due   (results_due)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Output side: random stalls, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_item(input vrm_pkg::cmd_t cmd, input logic [2:0] src,
                             input logic [3:0] ch, input int volts);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {volts[16:0], ch, src};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_random();
        int            pick;
        vrm_pkg::cmd_t cmd;
        logic [2:0]    src;
        logic [3:0]    ch;
        int            volts;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            cmd = vrm_pkg::CMD_GET;
        else if (pick < 75)
            cmd = vrm_pkg::CMD_SET;
        else if (pick < 95)
            cmd = vrm_pkg::CMD_MUX;
        else
            cmd = vrm_pkg::CMD_NONE;
        if ($urandom_range(0, 9) == 0)
            src = 3'($urandom_range(SRC_UNUSED_FIRST, SRC_UNUSED_LAST));
        else
            src = 3'($urandom_range(vrm_pkg::SRC_VCC, vrm_pkg::SRC_MUX));
        // Supply writes are kept rare since each one walks the whole table.
        if (cmd == vrm_pkg::CMD_SET)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 3)
                src = vrm_pkg::SRC_VCC;
            else if (pick < 9)
                src = vrm_pkg::SRC_AREF;
            else if (pick < 18)
                src = vrm_pkg::SRC_BANDGAP;
        end
        if ($urandom_range(0, 7) == 0)
            ch = 4'($urandom_range(vrm_pkg::CHANNELS, 15));
        else
            ch = 4'($urandom_range(0, vrm_pkg::CHANNELS - 1));
        if ($urandom_range(0, 5) == 0)
            volts = $urandom_range(0, 17'h1FFFF);
        else if (cmd == vrm_pkg::CMD_SET && src == vrm_pkg::SRC_VCC)
            volts = $urandom_range(2000, 65535);
        else
            volts = $urandom_range(0, 24000);
        send_item(cmd, src, ch, volts);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Until the supply has been set, only a supply write is allowed.
        send_item(vrm_pkg::CMD_GET, vrm_pkg::SRC_VCC, 0, 0);
        send_item(vrm_pkg::CMD_SET, vrm_pkg::SRC_AREF, 0, 2048);
        send_item(vrm_pkg::CMD_MUX, vrm_pkg::SRC_AVCC, 1, 0);
        send_item(vrm_pkg::CMD_SET, vrm_pkg::SRC_VCC, 0, -65536);
        send_item(vrm_pkg::CMD_SET, vrm_pkg::SRC_VCC, 0, 20480);
        send_item(vrm_pkg::CMD_GET, vrm_pkg::SRC_VCC, 0, 0);
        send_item(vrm_pkg::CMD_GET, vrm_pkg::SRC_AVCC, 0, 0);
        send_item(vrm_pkg::CMD_GET, SRC_UNUSED_LAST, 0, 0);
        send_item(vrm_pkg::CMD_GET, vrm_pkg::SRC_MUX, 15, 0);
        send_item(vrm_pkg::CMD_SET, vrm_pkg::SRC_AREF, 0, 65535);
        send_item(vrm_pkg::CMD_SET, vrm_pkg::SRC_AREF, 0, -1);
        send_item(vrm_pkg::CMD_SET, vrm_pkg::SRC_BANDGAP, 0, 65535);
        send_item(vrm_pkg::CMD_SET, vrm_pkg::SRC_BANDGAP, 1, -65536);
        send_item(vrm_pkg::CMD_SET, vrm_pkg::SRC_BANDGAP, 2, 4915);
        send_item(vrm_pkg::CMD_SET, vrm_pkg::SRC_BANDGAP, 9, 100);
        send_item(vrm_pkg::CMD_SET, vrm_pkg::SRC_AVCC, 0, 0);
        send_item(vrm_pkg::CMD_SET, vrm_pkg::SRC_MUX, 0, 0);
        send_item(vrm_pkg::CMD_MUX, vrm_pkg::SRC_VCC, 3, 0);
        send_item(vrm_pkg::CMD_MUX, vrm_pkg::SRC_AREF, 5, 0);
        send_item(vrm_pkg::CMD_MUX, vrm_pkg::SRC_MUX, 6, 0);
        send_item(vrm_pkg::CMD_MUX, vrm_pkg::SRC_BANDGAP, 7, 1000);
        send_item(vrm_pkg::CMD_MUX, vrm_pkg::SRC_BANDGAP, 2, -5);
        send_item(vrm_pkg::CMD_MUX, SRC_UNUSED_FIRST, 0, 0);
        send_item(vrm_pkg::CMD_MUX, vrm_pkg::SRC_VCC, 12, 0);
        send_item(vrm_pkg::CMD_NONE, vrm_pkg::SRC_VCC, 0, 0);
        send_item(vrm_pkg::CMD_SET, vrm_pkg::SRC_VCC, 0, 65535);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 83;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 83;
                end
                default:
                begin
                    idle_pct  = 27;
                    stall_pct = 27;
                end
            endcase
            for (int n = 0; n < ITEMS / 4; n++)
            begin
                // The output side stops for a while and the block backs up.
                if (phase == 0 && n == 20)
                    hold_req <= 1'b1;
                send_random();
            end
        end
        s_axis_tvalid <= 1'b0;

        while (results_due != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/vrm_pkg.sv
sv/vrm_table.sv
sv/vrm_div.sv
sv/voltage_reference_mux.sv
sim/vrm_result_checker.sv
sim/tb_voltage_reference_mux.sv
